// ----- hw/rtl/tpq_pkg.sv -----
// Shared types and codes for the three-class priority queue.
package tpq_pkg;

    // Number of service classes
    localparam int CLASS_COUNT = 3;
    localparam int ID_W        = 16;

    // Request action codes
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    // Severity codes carried by an enqueue request
    localparam logic [1:0] SEV_CRITICAL = 2'd3;
    localparam logic [1:0] SEV_SERIOUS  = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Served class codes
    localparam logic [1:0] CLASS_NONE     = 2'd0;
    localparam logic [1:0] CLASS_STABLE   = 2'd1;
    localparam logic [1:0] CLASS_SERIOUS  = 2'd2;
    localparam logic [1:0] CLASS_CRITICAL = 2'd3;

    // Per-class queue slot (0 stable, 1 serious, 2 critical)
    localparam logic [1:0] SLOT_STABLE   = 2'd0;
    localparam logic [1:0] SLOT_SERIOUS  = 2'd1;
    localparam logic [1:0] SLOT_CRITICAL = 2'd2;

    // Control into one class chain
    typedef struct packed {
        logic push;
        logic pop;
    } chain_ctrl_t;

    // Status out of one class chain
    typedef struct packed {
        logic            full;
        logic            empty;
        logic [ID_W-1:0] head_id;
    } chain_stat_t;

endpackage

// ----- hw/rtl/three_class_priority_queue_core.sv -----
// Top level of the three-class strict-priority queue.
//
// Requests arrive on the in_valid/in_ready channel: action 0 enqueues
// entry_id into the class chosen by severity_code (3 critical, 2 serious,
// anything else stable); action 1 dequeues the oldest entry of the highest
// non-empty class. Every request gives exactly one result on the
// out_valid/out_ready channel: status, served_id and served_class.
// Each class is a row of QUEUE_DEPTH shifting cells; the head cell is
// always at cell 0, so a request is executed in the cycle it is accepted.
// A result is registered for the next cycle; one request per cycle is
// sustained while the receiver takes results, limited by the single output
// register. When out_ready is low the result holds and in_ready drops
// until it is taken. Reset empties all three classes (counts to zero);
// no clearing pass is needed, and requests are accepted right after reset.
module three_class_priority_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [15:0] entry_id,
    input  logic [1:0]  severity_code,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] served_id,
    output logic [1:0]  served_class
);
    import tpq_pkg::*;

    chain_ctrl_t     ctrl [CLASS_COUNT];
    chain_stat_t     stat [CLASS_COUNT];
    logic            accept;
    logic [1:0]      enq_slot;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [1:0]      status_reg;
    logic [1:0]      status_next;
    logic [ID_W-1:0] served_id_reg;
    logic [ID_W-1:0] served_id_next;
    logic [1:0]      served_class_reg;
    logic [1:0]      served_class_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Severity to class slot
    always_comb
    begin
        case (severity_code)
            SEV_CRITICAL: enq_slot = SLOT_CRITICAL;
            SEV_SERIOUS:  enq_slot = SLOT_SERIOUS;
            default:      enq_slot = SLOT_STABLE;
        endcase
    end

    // Request decode, priority select and result
    always_comb
    begin
        for (int s = 0; s < CLASS_COUNT; s++)
        begin
            ctrl[s].push = 1'b0;
            ctrl[s].pop  = 1'b0;
        end
        status_next       = STATUS_OK;
        served_id_next    = '0;
        served_class_next = CLASS_NONE;

        if (action == ACT_ENQUEUE)
        begin
            if (stat[enq_slot].full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                ctrl[enq_slot].push = accept;
            end
        end
        else if (!stat[SLOT_CRITICAL].empty)
        begin
            ctrl[SLOT_CRITICAL].pop = accept;
            served_id_next          = stat[SLOT_CRITICAL].head_id;
            served_class_next       = CLASS_CRITICAL;
        end
        else if (!stat[SLOT_SERIOUS].empty)
        begin
            ctrl[SLOT_SERIOUS].pop = accept;
            served_id_next         = stat[SLOT_SERIOUS].head_id;
            served_class_next      = CLASS_SERIOUS;
        end
        else if (!stat[SLOT_STABLE].empty)
        begin
            ctrl[SLOT_STABLE].pop = accept;
            served_id_next        = stat[SLOT_STABLE].head_id;
            served_class_next     = CLASS_STABLE;
        end
        else
        begin
            status_next = STATUS_EMPTY;
        end
    end

    // One FIFO chain per class
    for (genvar s = 0; s < CLASS_COUNT; s++)
    begin : g_class
        tpq_chain #(
            .DEPTH (QUEUE_DEPTH)
        ) u_chain (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl[s]),
            .push_id (entry_id),
            .stat    (stat[s])
        );
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, loaded on each accepted request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg       <= status_next;
            served_id_reg    <= served_id_next;
            served_class_reg <= served_class_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign served_id    = served_id_reg;
    assign served_class = served_class_reg;

    // A rejected or empty result carries no identifier or class
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> (served_id == '0) && (served_class == CLASS_NONE))
    else $error("non-ok result carries served data");

    // A served class always comes with an ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (served_class != CLASS_NONE) |-> (status == STATUS_OK))
    else $error("served class with non-ok status");

    // Every accepted request shows a result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

    // At most one class chain changes per request
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({ctrl[0].push, ctrl[0].pop, ctrl[1].push, ctrl[1].pop,
                    ctrl[2].push, ctrl[2].pop}) <= 1)
    else $error("more than one chain operation in a cycle");

endmodule

// ----- hw/rtl/tpq_cell.sv -----
// One storage cell of a class chain: loads on push at its slot, shifts toward the head on pop.
module tpq_cell #(
    parameter int CNT_W = 5,
    parameter int INDEX = 0
) (
    input  logic                 clk,
    input  tpq_pkg::chain_ctrl_t ctrl,
    input  logic [CNT_W-1:0]     count,
    input  logic [15:0]          push_id,
    input  logic [15:0]          neighbor_id,
    output logic [15:0]          id
);
    import tpq_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic            load_here;

    // A push lands in the first free cell, which sits at the current count
    assign load_here = ctrl.push && (count == CNT_W'(INDEX));

    always_comb
    begin
        id_next = id_reg;
        if (ctrl.pop)
        begin
            id_next = neighbor_id;
        end
        else if (load_here)
        begin
            id_next = push_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign id = id_reg;

endmodule

// ----- hw/rtl/tpq_chain.sv -----
// FIFO for one class built as a row of shifting cells plus an occupancy count.
module tpq_chain #(
    parameter int DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpq_pkg::chain_ctrl_t ctrl,
    input  logic [15:0]          push_id,
    output tpq_pkg::chain_stat_t stat
);
    import tpq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [ID_W-1:0]  cell_id [DEPTH];
    logic             full;
    logic             empty;
    chain_ctrl_t      cell_ctrl;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Guard the requests so the cells never see an impossible operation
    assign cell_ctrl.push = ctrl.push && !full;
    assign cell_ctrl.pop  = ctrl.pop && !empty;

    // Row of cells; each takes its upstream neighbor on pop, the tail keeps itself
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0] nb_id;
        if (i == DEPTH - 1)
        begin : g_tail
            assign nb_id = cell_id[i];
        end
        else
        begin : g_mid
            assign nb_id = cell_id[i+1];
        end

        tpq_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .count       (count_reg),
            .push_id     (push_id),
            .neighbor_id (nb_id),
            .id          (cell_id[i])
        );
    end

    // Occupancy count
    always_comb
    begin
        count_next = count_reg;
        if (cell_ctrl.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cell_ctrl.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.full    = full;
    assign stat.empty   = empty;
    assign stat.head_id = cell_id[0];

endmodule
